@@ design/hpr_pkg.sv @@
// Shared types and constants for the HPACK representation parser.
// Used by the front classifier, the byte queue, the back parser and the top level.
// No dependencies.
`default_nettype none

package hpr_pkg;

    // Default width of the integer accumulator and string length counter.
    localparam int VALUE_BITS_DEF = 32;

    // Number of classified bytes held between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    localparam logic [6:0] PREFIX_7 = 7'h7f;
    localparam logic [6:0] PREFIX_6 = 7'h3f;
    localparam logic [6:0] PREFIX_5 = 7'h1f;
    localparam logic [6:0] PREFIX_4 = 7'h0f;

    typedef enum logic [2:0] {
        EV_INDEXED    = 3'd0,
        EV_LIT_INC    = 3'd1,
        EV_SIZE_UPD   = 3'd2,
        EV_LIT_NOIDX  = 3'd3,
        EV_STR_HDR    = 3'd4,
        EV_STR_BYTE   = 3'd5,
        EV_TRUNCATED  = 3'd6,
        EV_RESERVED   = 3'd7
    } t_event;

    // One header block byte together with its classification as the first byte
    // of a representation.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        t_event     kind;
        logic [6:0] limit;
        logic [6:0] prefix;
        logic       prefix_full;
    } t_byte_info;

    typedef struct packed {
        t_event      event_res;
        logic [31:0] value;
        logic        is_value_string;
        logic        huffman;
        logic [7:0]  string_byte;
        logic        last_of_string;
    } t_result;

endpackage

`default_nettype wire

@@ design/hpack_representation_parser.sv @@
// HPACK representation parser, top level. Each accepted byte is queued, and its
// result is registered for output when the back parser pops it. Throughput: one
// header byte per cycle while the queue is not full; the back parser takes one
// queued byte a cycle whenever its output register is empty or being drained.
// Reset (synchronous, active low) empties the queue, returns the parser to idle
// and drops the output valid at once; no clearing pass is needed.
// Depends on hpr_pkg, hpr_front, hpr_queue and hpr_back.
`default_nettype none

module hpack_representation_parser #(
    parameter int VALUE_BITS = hpr_pkg::VALUE_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,   // last_in_block
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // [31:0] value, [39:32] string_byte
    output logic [4:0]       m_axis_tuser,   // [2:0] event_res, [3] is_value_string,
                                             // [4] huffman
    output logic             m_axis_tlast    // last_of_string
);

    hpr_pkg::t_byte_info front_info;
    hpr_pkg::t_byte_info queue_info;
    hpr_pkg::t_result    result;
    logic                queue_full;
    logic                queue_empty;
    logic                queue_pop;

    hpr_front u_front (
        .i_data (s_axis_tdata),
        .i_last (s_axis_tlast),
        .o_info (front_info)
    );

    hpr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_axis_tvalid),
        .i_info  (front_info),
        .o_full  (queue_full),
        .i_pop   (queue_pop),
        .o_empty (queue_empty),
        .o_info  (queue_info)
    );

    hpr_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (queue_empty),
        .i_info   (queue_info),
        .o_pop    (queue_pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    assign s_axis_tready = !queue_full;
    assign m_axis_tdata  = {result.string_byte, result.value};
    assign m_axis_tuser  = {result.huffman, result.is_value_string, result.event_res};
    assign m_axis_tlast  = result.last_of_string;

endmodule

`default_nettype wire

@@ design/hpr_front.sv @@
// Front classifier: decodes the leading bits of each incoming byte into a
// representation kind and prefix. Depends on hpr_pkg.
`default_nettype none

module hpr_front (
    input  wire logic [7:0]          i_data,
    input  wire logic                i_last,
    output hpr_pkg::t_byte_info      o_info
);

    logic [6:0]      limit;
    hpr_pkg::t_event kind;
    logic [6:0]      prefix;

    always_comb begin
        priority if (i_data[7]) begin
            kind  = hpr_pkg::EV_INDEXED;
            limit = hpr_pkg::PREFIX_7;
        end else if (i_data[6]) begin
            kind  = hpr_pkg::EV_LIT_INC;
            limit = hpr_pkg::PREFIX_6;
        end else if (i_data[5]) begin
            kind  = hpr_pkg::EV_SIZE_UPD;
            limit = hpr_pkg::PREFIX_5;
        end else begin
            kind  = hpr_pkg::EV_LIT_NOIDX;
            limit = hpr_pkg::PREFIX_4;
        end
        prefix = i_data[6:0] & limit;
    end

    assign o_info.data        = i_data;
    assign o_info.last        = i_last;
    assign o_info.kind        = kind;
    assign o_info.limit       = limit;
    assign o_info.prefix      = prefix;
    assign o_info.prefix_full = (prefix == limit);

endmodule

`default_nettype wire

@@ design/hpr_queue.sv @@
// Short queue of classified bytes between the front and the back parser.
// Depends on hpr_pkg.
`default_nettype none

module hpr_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire hpr_pkg::t_byte_info i_info,
    output logic                     o_full,
    input  wire logic                i_pop,
    output logic                     o_empty,
    output hpr_pkg::t_byte_info      o_info
);

    localparam int AW = $clog2(hpr_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(hpr_pkg::QUEUE_DEPTH + 1);

    hpr_pkg::t_byte_info r_mem [hpr_pkg::QUEUE_DEPTH];
    logic [AW-1:0]       r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]       r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]       r_count, n_count;
    logic                do_push, do_pop;

    assign o_full  = (r_count == CW'(hpr_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_info  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(hpr_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(hpr_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        unique case ({do_push, do_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_info;
        end
    end

endmodule

`default_nettype wire

@@ design/hpr_back.sv @@
// Back parser: walks the representation state machine over queued bytes,
// decodes prefix integers and string lengths, and holds the result register.
// Depends on hpr_pkg.
`default_nettype none

module hpr_back #(
    parameter int VALUE_BITS = hpr_pkg::VALUE_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_empty,
    input  wire hpr_pkg::t_byte_info i_info,
    output logic                     o_pop,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output hpr_pkg::t_result         o_result
);

    localparam int VB = VALUE_BITS;
    localparam logic [VB-1:0] VMAX = '1;

    typedef enum logic [4:0] {
        PH_IDLE      = 5'b00001,
        PH_REP_INT   = 5'b00010,
        PH_STR_HDR   = 5'b00100,
        PH_STR_INT   = 5'b01000,
        PH_STR_BYTES = 5'b10000
    } t_phase;

    t_phase           r_phase, n_phase;
    logic [VB-1:0]    r_acc, n_acc;
    logic [5:0]       r_shift, n_shift;
    logic [6:0]       r_limit, n_limit;
    hpr_pkg::t_event  r_kind, n_kind;
    logic [VB-1:0]    r_remain, n_remain;
    logic [1:0]       r_strings, n_strings;
    logic             r_huff, n_huff;

    logic             r_out_valid;
    hpr_pkg::t_result r_out;

    // Integer continuation datapath shared by both integer phases.
    logic [6:0]       grp;
    logic [VB+6:0]    grp_shifted;
    logic [VB-1:0]    acc_grp;
    logic [5:0]       shift_grp;
    logic [VB:0]      fin_sum;
    logic [VB-1:0]    fin;

    logic             emit;
    hpr_pkg::t_event  ev;
    logic [VB-1:0]    val;
    logic [VB+31:0]   val_ext;
    logic             isv, huf, los;
    logic [7:0]       sb;

    logic             do_rep, do_str, do_end;
    hpr_pkg::t_event  rep_kind;
    logic [VB-1:0]    rep_val, str_len;
    logic [1:0]       strings_dec;

    assign o_pop = !i_empty && (!r_out_valid || i_ready);

    always_comb begin
        grp         = i_info.data[6:0];
        grp_shifted = (VB+7)'(grp) << r_shift;
        acc_grp     = r_acc;
        if (grp != '0) begin
            if (r_shift >= 6'd63 || int'(r_shift) >= VB) begin
                acc_grp = VMAX;
            end else if (grp_shifted[VB+6:VB] != '0) begin
                acc_grp = VMAX;
            end else begin
                acc_grp = r_acc | grp_shifted[VB-1:0];
            end
        end
        shift_grp = (r_shift >= 6'd56) ? 6'd63 : r_shift + 6'd7;
        fin_sum   = {1'b0, acc_grp} + (VB+1)'(r_limit);
        fin       = fin_sum[VB] ? VMAX : fin_sum[VB-1:0];
    end

    always_comb begin
        n_phase   = r_phase;
        n_acc     = r_acc;
        n_shift   = r_shift;
        n_limit   = r_limit;
        n_kind    = r_kind;
        n_remain  = r_remain;
        n_strings = r_strings;
        n_huff    = r_huff;

        emit = 1'b0;
        ev   = hpr_pkg::EV_INDEXED;
        val  = '0;
        isv  = 1'b0;
        huf  = 1'b0;
        sb   = '0;
        los  = 1'b0;

        do_rep   = 1'b0;
        do_str   = 1'b0;
        do_end   = 1'b0;
        rep_kind = i_info.kind;
        rep_val  = '0;
        str_len  = '0;

        unique case (r_phase)
            PH_REP_INT: begin
                n_acc   = acc_grp;
                n_shift = shift_grp;
                if (!i_info.data[7]) begin
                    do_rep   = 1'b1;
                    rep_kind = r_kind;
                    rep_val  = fin;
                end
            end
            PH_STR_HDR: begin
                n_huff = i_info.data[7];
                if (i_info.data[6:0] != hpr_pkg::PREFIX_7) begin
                    do_str  = 1'b1;
                    str_len = VB'(i_info.data[6:0]);
                end else begin
                    n_acc   = '0;
                    n_shift = '0;
                    n_limit = hpr_pkg::PREFIX_7;
                    n_phase = PH_STR_INT;
                end
            end
            PH_STR_INT: begin
                n_acc   = acc_grp;
                n_shift = shift_grp;
                if (!i_info.data[7]) begin
                    do_str  = 1'b1;
                    str_len = fin;
                end
            end
            PH_STR_BYTES: begin
                emit     = 1'b1;
                ev       = hpr_pkg::EV_STR_BYTE;
                isv      = (r_strings == 2'd1);
                huf      = r_huff;
                sb       = i_info.data;
                los      = (r_remain <= VB'(1));
                n_remain = (r_remain != '0) ? r_remain - 1'b1 : '0;
                if (n_remain == '0) begin
                    do_end = 1'b1;
                end
            end
            default: begin
                // Idle, and any corrupted phase code, starts a representation.
                if (!i_info.prefix_full) begin
                    do_rep   = 1'b1;
                    rep_kind = i_info.kind;
                    rep_val  = VB'(i_info.prefix);
                end else begin
                    n_acc   = '0;
                    n_shift = '0;
                    n_limit = i_info.limit;
                    n_kind  = i_info.kind;
                    n_phase = PH_REP_INT;
                end
            end
        endcase

        if (do_rep) begin
            emit = 1'b1;
            ev   = rep_kind;
            val  = rep_val;
            if (rep_kind == hpr_pkg::EV_INDEXED || rep_kind == hpr_pkg::EV_SIZE_UPD) begin
                n_phase = PH_IDLE;
            end else begin
                n_strings = (rep_val == '0) ? 2'd2 : 2'd1;
                n_phase   = PH_STR_HDR;
            end
        end

        if (do_str) begin
            emit = 1'b1;
            ev   = hpr_pkg::EV_STR_HDR;
            val  = str_len;
            isv  = (r_strings == 2'd1);
            huf  = n_huff;
            los  = (str_len == '0);
            if (str_len == '0) begin
                do_end = 1'b1;
            end else begin
                n_remain = str_len;
                n_phase  = PH_STR_BYTES;
            end
        end

        strings_dec = (r_strings != '0) ? r_strings - 1'b1 : '0;
        if (do_end) begin
            n_strings = strings_dec;
            n_phase   = (strings_dec != '0) ? PH_STR_HDR : PH_IDLE;
        end

        // The last byte of a block always returns the parser to its reset state;
        // an unfinished representation is reported instead of this byte's event.
        if (i_info.last) begin
            if (n_phase != PH_IDLE) begin
                emit = 1'b1;
                ev   = hpr_pkg::EV_TRUNCATED;
                val  = '0;
                isv  = 1'b0;
                huf  = 1'b0;
                sb   = '0;
                los  = 1'b0;
            end
            n_phase   = PH_IDLE;
            n_acc     = '0;
            n_shift   = '0;
            n_limit   = '0;
            n_kind    = hpr_pkg::EV_INDEXED;
            n_remain  = '0;
            n_strings = '0;
            n_huff    = 1'b0;
        end

        val_ext = {32'b0, val};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_acc       <= '0;
            r_shift     <= '0;
            r_limit     <= '0;
            r_kind      <= hpr_pkg::EV_INDEXED;
            r_remain    <= '0;
            r_strings   <= '0;
            r_huff      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase     <= n_phase;
                r_acc       <= n_acc;
                r_shift     <= n_shift;
                r_limit     <= n_limit;
                r_kind      <= n_kind;
                r_remain    <= n_remain;
                r_strings   <= n_strings;
                r_huff      <= n_huff;
                r_out_valid <= emit;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_out.event_res       <= ev;
            r_out.value           <= val_ext[31:0];
            r_out.is_value_string <= isv;
            r_out.huffman         <= huf;
            r_out.string_byte     <= sb;
            r_out.last_of_string  <= los;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

`default_nettype wire
